@@ sv/assert_macros.svh @@
// shared assertion macros for the safety checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is high
`define BSC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked on every rising edge, reset included
`define BSC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bsc_pkg.sv @@
`timescale 1ns / 1ps

package bsc_pkg;

   // default sizes of the stores
   localparam int DEF_MAX_PROCESSES = 8;
   localparam int DEF_MAX_RESOURCES = 8;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int PIDX_W   = 3;
   localparam int RIDX_W   = 3;
   localparam int VALUE_W  = 16;
   localparam int PNUM_W   = 4;
   localparam int CFG_W    = 4;
   localparam int CSR_IDX_W = 2;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOAD_MAX   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RUN        = 2'd3;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PROCESSES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_RESOURCES = 2'd1;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // controller to datapath
   typedef struct packed {
      logic load_max;
      logic load_alloc;
      logic load_avail;
      logic init_run;
      logic next_proc;
      logic clr_proc;
      logic next_res;
      logic clr_res;
      logic add_work;
      logic mark;
      logic out_pick;
      logic out_unsafe;
   } bsc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic last_proc;
      logic last_res;
      logic fail;
      logic out_free;
      logic done;
   } bsc_status_type;

endpackage

@@ sv/bsc_datapath.sv @@
`timescale 1ns / 1ps

module bsc_datapath #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsc_pkg::CFG_W-1:0]        csr_data,
   input  logic [bsc_pkg::PIDX_W-1:0]       req_process_index,
   input  logic [bsc_pkg::RIDX_W-1:0]       req_resource_index,
   input  logic [bsc_pkg::VALUE_W-1:0]      req_value,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [bsc_pkg::PNUM_W-1:0]       rsp_process_number,
   output logic                             rsp_unsafe,
   output logic                             rsp_last,
   input  bsc_pkg::bsc_cmd_type             cmd,
   output bsc_pkg::bsc_status_type          status
);

   localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int RCN_W = $clog2(MAX_RESOURCES + 1);
   localparam int EW0   = (CNT_W > RCN_W) ? CNT_W : RCN_W;
   localparam int EW    = (EW0 > bsc_pkg::CFG_W) ? EW0 : bsc_pkg::CFG_W;
   localparam int NW    = PIW + 1;
   localparam int VW    = bsc_pkg::VALUE_W;

   // matrices, one row of resources per process
   logic [VW-1:0] max_mem   [DEPTH];
   logic [VW-1:0] alloc_mem [DEPTH];
   logic [VW-1:0] max_q_ff;
   logic [VW-1:0] alloc_q_ff;

   logic [VW-1:0] avail_ff [MAX_RESOURCES];
   logic [VW-1:0] work_ff  [MAX_RESOURCES];

   logic [bsc_pkg::CFG_W-1:0] num_proc_ff;
   logic [bsc_pkg::CFG_W-1:0] num_res_ff;

   logic [PIW-1:0]           proc_ff;
   logic [PIW-1:0]           proc_in;
   logic [RIW-1:0]           res_ff;
   logic [RIW-1:0]           res_in;
   logic [MAX_PROCESSES-1:0] marks_ff;
   logic [CNT_W-1:0]         fin_cnt_ff;

   logic                     rsp_valid_ff;
   logic [bsc_pkg::PNUM_W-1:0] rsp_num_ff;
   logic                     rsp_unsafe_ff;
   logic                     rsp_last_ff;

   logic [EW-1:0] np_ext;
   logic [EW-1:0] nr_ext;
   logic [EW-1:0] np_eff;
   logic [EW-1:0] nr_eff;
   logic          pi_ok;
   logic          ri_ok;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [VW-1:0] work_cur;
   logic [VW-1:0] need;
   logic [VW:0]   sum;
   logic [VW-1:0] sum_sat;
   logic [NW-1:0] pick_num;

   // effective counts: zero acts as one, above the store size acts as the size
   assign np_ext = EW'(num_proc_ff);
   assign nr_ext = EW'(num_res_ff);
   assign np_eff = (num_proc_ff == '0) ? EW'(1) :
                   ((np_ext > EW'(MAX_PROCESSES)) ? EW'(MAX_PROCESSES) : np_ext);
   assign nr_eff = (num_res_ff == '0) ? EW'(1) :
                   ((nr_ext > EW'(MAX_RESOURCES)) ? EW'(MAX_RESOURCES) : nr_ext);

   assign pi_ok   = 8'(req_process_index) < 8'(MAX_PROCESSES);
   assign ri_ok   = 8'(req_resource_index) < 8'(MAX_RESOURCES);
   assign wr_addr = AW'(PIW'(req_process_index)) * AW'(MAX_RESOURCES)
                    + AW'(RIW'(req_resource_index));
   assign rd_addr = AW'(proc_ff) * AW'(MAX_RESOURCES) + AW'(res_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_max && pi_ok && ri_ok) begin
         max_mem[wr_addr] <= req_value;
      end
      if (cmd.load_alloc && pi_ok && ri_ok) begin
         alloc_mem[wr_addr] <= req_value;
      end
      max_q_ff   <= max_mem[rd_addr];
      alloc_q_ff <= alloc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_avail && ri_ok) begin
         avail_ff[RIW'(req_resource_index)] <= req_value;
      end
   end

   // need clamped at zero for the fit test against the working vector, and the saturating update sum
   assign work_cur = work_ff[res_ff];
   assign need     = (max_q_ff > alloc_q_ff) ? (max_q_ff - alloc_q_ff) : '0;
   assign sum      = {1'b0, work_cur} + {1'b0, alloc_q_ff};
   assign sum_sat  = sum[VW] ? {VW{1'b1}} : sum[VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_RESOURCES; k++) begin
            work_ff[k] <= '0;
         end
      end else if (cmd.init_run) begin
         for (int k = 0; k < MAX_RESOURCES; k++) begin
            work_ff[k] <= avail_ff[k];
         end
      end else if (cmd.add_work) begin
         work_ff[res_ff] <= sum_sat;
      end
   end

   always_comb begin
      proc_in = proc_ff;
      if (cmd.init_run || cmd.clr_proc) begin
         proc_in = '0;
      end else if (cmd.next_proc) begin
         proc_in = proc_ff + PIW'(1);
      end
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.init_run || cmd.clr_res) begin
         res_in = '0;
      end else if (cmd.next_res) begin
         res_in = res_ff + RIW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_ff     <= '0;
         res_ff      <= '0;
         marks_ff    <= '0;
         fin_cnt_ff  <= '0;
         num_proc_ff <= bsc_pkg::CFG_RESET;
         num_res_ff  <= bsc_pkg::CFG_RESET;
      end else begin
         proc_ff <= proc_in;
         res_ff  <= res_in;
         if (cmd.init_run) begin
            marks_ff   <= '0;
            fin_cnt_ff <= '0;
         end else if (cmd.mark) begin
            marks_ff[proc_ff] <= 1'b1;
            fin_cnt_ff        <= fin_cnt_ff + CNT_W'(1);
         end
         if (csr_wr && csr_index == bsc_pkg::CSR_NUM_PROCESSES) begin
            num_proc_ff <= csr_data;
         end
         if (csr_wr && csr_index == bsc_pkg::CSR_NUM_RESOURCES) begin
            num_res_ff <= csr_data;
         end
      end
   end

   // result register
   assign pick_num = NW'(proc_ff) + NW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_pick || cmd.out_unsafe) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_pick) begin
         rsp_num_ff    <= bsc_pkg::PNUM_W'(pick_num);
         rsp_unsafe_ff <= 1'b0;
         rsp_last_ff   <= status.done;
      end else if (cmd.out_unsafe) begin
         rsp_num_ff    <= '0;
         rsp_unsafe_ff <= 1'b1;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_process_number = rsp_num_ff;
   assign rsp_unsafe         = rsp_unsafe_ff;
   assign rsp_last           = rsp_last_ff;

   assign status.skip      = marks_ff[proc_ff];
   assign status.last_proc = EW'(proc_ff) == (np_eff - EW'(1));
   assign status.last_res  = EW'(res_ff) == (nr_eff - EW'(1));
   assign status.fail      = work_cur < need;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.done      = EW'(fin_cnt_ff) == np_eff;

endmodule

@@ sv/bsc_ctrl.sv @@
`timescale 1ns / 1ps

module bsc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsc_pkg::CMD_W-1:0]     req_command,
   input  bsc_pkg::bsc_status_type       status,
   output bsc_pkg::bsc_cmd_type          cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_CHK    = 3'd2;
   localparam logic [2:0] S_CWAIT  = 3'd3;
   localparam logic [2:0] S_AWAIT  = 3'd4;
   localparam logic [2:0] S_ADD    = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;
   localparam logic [2:0] S_UNSAFE = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  bsc_pkg::CMD_LOAD_MAX:   cmd.load_max   = 1'b1;
                  bsc_pkg::CMD_LOAD_ALLOC: cmd.load_alloc = 1'b1;
                  bsc_pkg::CMD_LOAD_AVAIL: cmd.load_avail = 1'b1;
                  bsc_pkg::CMD_RUN: begin
                     cmd.init_run = 1'b1;
                     state_in     = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // memory is reading resource zero of this process
            if (status.skip) begin
               if (status.last_proc) begin
                  state_in = S_UNSAFE;
               end else begin
                  cmd.next_proc = 1'b1;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (status.fail) begin
               cmd.clr_res = 1'b1;
               if (status.last_proc) begin
                  state_in = S_UNSAFE;
               end else begin
                  cmd.next_proc = 1'b1;
                  state_in      = S_SCAN;
               end
            end else if (status.last_res) begin
               cmd.clr_res = 1'b1;
               state_in    = S_AWAIT;
            end else begin
               cmd.next_res = 1'b1;
               state_in     = S_CWAIT;
            end
         end
         S_CWAIT: state_in = S_CHK;
         S_AWAIT: state_in = S_ADD;
         S_ADD: begin
            cmd.add_work = 1'b1;
            if (status.last_res) begin
               cmd.mark    = 1'b1;
               cmd.clr_res = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.next_res = 1'b1;
               state_in     = S_AWAIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_pick = 1'b1;
               if (status.done) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.clr_proc = 1'b1;
                  state_in     = S_SCAN;
               end
            end
         end
         S_UNSAFE: begin
            if (status.out_free) begin
               cmd.out_unsafe = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/bankers_safety_check.sv @@
`timescale 1ns / 1ps

// banker's algorithm safety checker. load words write one entry of the
// maximum-need or allocation matrix, or one available count, and give no
// result word. a run word copies the available counts into a working
// vector, then picks the lowest-numbered unfinished process whose need (max
// minus allocation, floored at zero) fits, adds its allocation with
// saturation and returns its 1-based number; the final pick has last set,
// and a run that gets stuck ends with one unsafe word instead. the two
// matrices sit in memories with a separate write address and registered
// reads, so each resource compare or update waits for the read of its entry;
// a process that fits is walked again to add its allocation. a new word is
// taken only once the run is over, though a result word may still wait at
// the output. the user must write num_processes and num_resources through
// the csr port only while idle; the block itself does not enforce this.
// zero acts as one and values above the store size act as the store size

module bankers_safety_check #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
   input  logic                          clock,
   input  logic                          reset,
   // request words
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsc_pkg::CMD_W-1:0]     req_command,
   input  logic [bsc_pkg::PIDX_W-1:0]    req_process_index,
   input  logic [bsc_pkg::RIDX_W-1:0]    req_resource_index,
   input  logic [bsc_pkg::VALUE_W-1:0]   req_value,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsc_pkg::PNUM_W-1:0]    rsp_process_number,
   output logic                          rsp_unsafe,
   output logic                          rsp_last,
   // control registers
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsc_pkg::CFG_W-1:0]     csr_data
);

   bsc_pkg::bsc_cmd_type    cmd;
   bsc_pkg::bsc_status_type status;

   // register writes always land at once
   assign csr_ready = 1'b1;

   // sequencer: load decode, process scan, per-resource compare and update, result output
   bsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   // matrices, working vector, completion marks and the result register
   bsc_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_value          (req_value),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_process_number (rsp_process_number),
      .rsp_unsafe         (rsp_unsafe),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

@@ sv/bsc_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [bsc_pkg::CMD_W-1:0]     req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bsc_pkg::PNUM_W-1:0]    rsp_process_number,
   input logic                          rsp_unsafe,
   input logic                          rsp_last
);

   // the unsafe word is always the closing word and names no process
   `BSC_ASSERT(a_unsafe_word, clock, reset, rsp_valid && rsp_unsafe |-> rsp_last && rsp_process_number == '0, "unsafe word malformed")

   // a run blocks further requests on the following cycle
   `BSC_ASSERT(a_run_blocks, clock, reset, req_valid && req_ready && req_command == bsc_pkg::CMD_RUN |=> !req_ready, "request taken during run")

   // nothing is offered straight after reset
   `BSC_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result after reset")

   // a stalled result word holds
   `BSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_process_number) && $stable(rsp_unsafe) && $stable(rsp_last), "stalled result changed")

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_command        (req_command),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_process_number (rsp_process_number),
   .rsp_unsafe         (rsp_unsafe),
   .rsp_last           (rsp_last)
);

@@ tb/tb_bankers_safety_check.sv @@
`timescale 1ns / 1ps

module tb_bankers_safety_check;

   localparam int NPROC        = bsc_pkg::DEF_MAX_PROCESSES;
   localparam int NRES         = bsc_pkg::DEF_MAX_RESOURCES;
   // cycles with no word moving on any channel before the run is abandoned
   localparam int STALL_LIMIT  = 20000;
   // ample settling time for the last load before touching the csrs
   localparam int LOAD_SETTLE  = 16;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   // request words over the whole run
   localparam int TOTAL_WORDS  = 480;

   typedef struct packed {
      logic [bsc_pkg::PNUM_W-1:0] process_number;
      logic                       unsafe;
      logic                       last;
   } result_word_type;

   // every input starts at a known value
   logic                          clock              = 1'b0;
   logic                          reset              = 1'b1;
   logic                          req_valid          = 1'b0;
   logic                          req_ready;
   logic [bsc_pkg::CMD_W-1:0]     req_command        = bsc_pkg::CMD_LOAD_MAX;
   logic [bsc_pkg::PIDX_W-1:0]    req_process_index  = '0;
   logic [bsc_pkg::RIDX_W-1:0]    req_resource_index = '0;
   logic [bsc_pkg::VALUE_W-1:0]   req_value          = '0;
   logic                          rsp_valid;
   logic                          rsp_ready          = 1'b0;
   logic [bsc_pkg::PNUM_W-1:0]    rsp_process_number;
   logic                          rsp_unsafe;
   logic                          rsp_last;
   logic                          csr_valid          = 1'b0;
   logic                          csr_ready;
   logic [bsc_pkg::CSR_IDX_W-1:0] csr_index          = bsc_pkg::CSR_NUM_PROCESSES;
   logic [bsc_pkg::CFG_W-1:0]     csr_data           = '0;

   // own copy of the block's tables and registers
   logic [bsc_pkg::VALUE_W-1:0] need_ceiling [NPROC][NRES];
   logic [bsc_pkg::VALUE_W-1:0] allocation   [NPROC][NRES];
   logic [bsc_pkg::VALUE_W-1:0] available    [NRES];
   bit                          max_written   [NPROC][NRES];
   bit                          alloc_written [NPROC][NRES];
   bit                          avail_written [NRES];
   logic [bsc_pkg::CFG_W-1:0]   cfg_processes = bsc_pkg::CFG_RESET;
   logic [bsc_pkg::CFG_W-1:0]   cfg_resources = bsc_pkg::CFG_RESET;

   // completions still owed by the block, oldest first
   result_word_type pending_completions[$];

   // pacing controls shared by the stimulus and the receiver
   bit no_idle      = 1'b0;
   bit hold_pending = 1'b0;

   int words_sent   = 0;
   int loads_sent   = 0;
   int runs_sent    = 0;
   int csr_writes   = 0;
   int picks_seen   = 0;
   int unsafe_seen  = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;

   bankers_safety_check dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_process_number (rsp_process_number),
      .rsp_unsafe         (rsp_unsafe),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #1 clock = ~clock;

   // zero behaves as one, anything past the store size as the store size
   function automatic int effective_count(input logic [bsc_pkg::CFG_W-1:0] v, input int hi);
      if (v == 0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // mostly small sizes, now and then zero or beyond the store size
   function automatic logic [bsc_pkg::CFG_W-1:0] random_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return bsc_pkg::CFG_W'($urandom_range(9, 15));
      if (roll < 75) return bsc_pkg::CFG_W'($urandom_range(1, 4));
      return bsc_pkg::CFG_W'($urandom_range(5, 8));
   endfunction

   // walk the safety order on the current tables and queue every completion
   function automatic void predict_safe_order();
      int                          np, nr, pick, done_count;
      logic [bsc_pkg::VALUE_W-1:0] work [NRES];
      bit                          done [NPROC];
      bit                          fits;
      logic [bsc_pkg::VALUE_W-1:0] need;
      logic [bsc_pkg::VALUE_W:0]   sum;
      np = effective_count(cfg_processes, NPROC);
      nr = effective_count(cfg_resources, NRES);
      for (int r = 0; r < NRES; r++) work[r] = available[r];
      for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
      done_count = 0;
      while (done_count < np) begin
         pick = -1;
         for (int p = 0; p < np && pick < 0; p++) begin
            if (!done[p]) begin
               fits = 1'b1;
               for (int r = 0; r < nr; r++) begin
                  // remaining need floors at zero when allocation exceeds max
                  need = (need_ceiling[p][r] > allocation[p][r]) ?
                         need_ceiling[p][r] - allocation[p][r] : '0;
                  if (work[r] < need) fits = 1'b0;
               end
               if (fits) pick = p;
            end
         end
         if (pick < 0) begin
            // stuck before everyone finished: one unsafe verdict ends the run
            pending_completions.push_back('{process_number: '0, unsafe: 1'b1, last: 1'b1});
            return;
         end
         for (int r = 0; r < nr; r++) begin
            sum = {1'b0, work[r]} + {1'b0, allocation[pick][r]};
            work[r] = sum[bsc_pkg::VALUE_W] ? {bsc_pkg::VALUE_W{1'b1}} :
                      sum[bsc_pkg::VALUE_W-1:0];
         end
         done[pick] = 1'b1;
         done_count++;
         pending_completions.push_back('{process_number: bsc_pkg::PNUM_W'(pick + 1),
                                        unsafe: 1'b0, last: (done_count == np)});
      end
   endfunction

   // offer one request word and hold it until taken, then update the model
   task automatic send_word(input logic [bsc_pkg::CMD_W-1:0] cmd,
                            input logic [bsc_pkg::PIDX_W-1:0] pidx,
                            input logic [bsc_pkg::RIDX_W-1:0] ridx,
                            input logic [bsc_pkg::VALUE_W-1:0] val);
      bit took;
      while (!no_idle && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_process_index  <= pidx;
      req_resource_index <= ridx;
      req_value          <= val;
      // ready is stable by the falling edge, so decide there what the next rise does
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      words_sent++;
      case (cmd)
         bsc_pkg::CMD_LOAD_MAX: begin
            need_ceiling[pidx][ridx] = val;
            max_written[pidx][ridx]  = 1'b1;
            loads_sent++;
         end
         bsc_pkg::CMD_LOAD_ALLOC: begin
            allocation[pidx][ridx]    = val;
            alloc_written[pidx][ridx] = 1'b1;
            loads_sent++;
         end
         bsc_pkg::CMD_LOAD_AVAIL: begin
            // row index means nothing here
            available[ridx]     = val;
            avail_written[ridx] = 1'b1;
            loads_sent++;
         end
         default: begin
            predict_safe_order();
            runs_sent++;
         end
      endcase
   endtask

   // a run with random filler in the unused fields; any entry in the active
   // region that was never loaded gets loaded first so nothing undefined is read
   task automatic run_check();
      int np, nr;
      np = effective_count(cfg_processes, NPROC);
      nr = effective_count(cfg_resources, NRES);
      for (int p = 0; p < np; p++) begin
         for (int r = 0; r < nr; r++) begin
            if (!max_written[p][r])
               send_word(bsc_pkg::CMD_LOAD_MAX, bsc_pkg::PIDX_W'(p), bsc_pkg::RIDX_W'(r),
                         bsc_pkg::VALUE_W'($urandom_range(0, 12)));
            if (!alloc_written[p][r])
               send_word(bsc_pkg::CMD_LOAD_ALLOC, bsc_pkg::PIDX_W'(p), bsc_pkg::RIDX_W'(r),
                         bsc_pkg::VALUE_W'($urandom_range(0, 12)));
         end
      end
      for (int r = 0; r < nr; r++)
         if (!avail_written[r])
            send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom),
                      bsc_pkg::RIDX_W'(r), bsc_pkg::VALUE_W'($urandom_range(0, 10)));
      send_word(bsc_pkg::CMD_RUN, bsc_pkg::PIDX_W'($urandom), bsc_pkg::RIDX_W'($urandom),
                bsc_pkg::VALUE_W'($urandom));
   endtask

   // a consistent state: small allocations and needs, so runs often go deep
   task automatic load_coherent_region(input int rows, input int cols);
      logic [bsc_pkg::VALUE_W-1:0] alloc_v, max_v;
      for (int p = 0; p < rows; p++) begin
         for (int r = 0; r < cols; r++) begin
            alloc_v = bsc_pkg::VALUE_W'($urandom_range(0, 12));
            // now and then max below allocation, so the need floors at zero
            if ($urandom_range(0, 9) == 0)
               max_v = bsc_pkg::VALUE_W'($urandom_range(0, alloc_v));
            else
               max_v = alloc_v + bsc_pkg::VALUE_W'($urandom_range(0, 8));
            send_word(bsc_pkg::CMD_LOAD_MAX, bsc_pkg::PIDX_W'(p), bsc_pkg::RIDX_W'(r), max_v);
            send_word(bsc_pkg::CMD_LOAD_ALLOC, bsc_pkg::PIDX_W'(p), bsc_pkg::RIDX_W'(r),
                      alloc_v);
         end
      end
      for (int r = 0; r < cols; r++)
         send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom), bsc_pkg::RIDX_W'(r),
                   bsc_pkg::VALUE_W'($urandom_range(0, 10)));
   endtask

   // sender drops valid and waits for the block to go quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_completions.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [bsc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bsc_pkg::CFG_W-1:0] data);
      bit took;
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 1'b0;
      if (idx == bsc_pkg::CSR_NUM_PROCESSES) cfg_processes = data;
      else if (idx == bsc_pkg::CSR_NUM_RESOURCES) cfg_resources = data;
      csr_writes++;
   endtask

   // full tables under the reset sizes, so the default counts are exercised
   task automatic test_reset_config();
      load_coherent_region(NPROC, NRES);
      run_check();
      run_check();
   endtask

   task automatic test_directed_cases();
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(1));
      csr_write(bsc_pkg::CSR_NUM_RESOURCES, bsc_pkg::CFG_W'(1));
      // need of three exactly fits three available
      send_word(bsc_pkg::CMD_LOAD_MAX, 3'd0, 3'd0, 16'd5);
      send_word(bsc_pkg::CMD_LOAD_ALLOC, 3'd0, 3'd0, 16'd2);
      send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom), 3'd0, 16'd3);
      run_check();
      // one short: unsafe
      send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom), 3'd0, 16'd2);
      run_check();
      // allocation above max, need floors at zero
      send_word(bsc_pkg::CMD_LOAD_MAX, 3'd0, 3'd0, 16'd0);
      send_word(bsc_pkg::CMD_LOAD_ALLOC, 3'd0, 3'd0, 16'hFFFF);
      send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom), 3'd0, 16'd0);
      run_check();
      // working count saturates, then the full-scale need still fits
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(2));
      send_word(bsc_pkg::CMD_LOAD_MAX, 3'd1, 3'd0, 16'hFFFF);
      send_word(bsc_pkg::CMD_LOAD_ALLOC, 3'd1, 3'd0, 16'd0);
      send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom), 3'd0, 16'd1);
      run_check();
      // the lower process must wait for the higher one
      send_word(bsc_pkg::CMD_LOAD_MAX, 3'd0, 3'd0, 16'd10);
      send_word(bsc_pkg::CMD_LOAD_ALLOC, 3'd0, 3'd0, 16'd0);
      send_word(bsc_pkg::CMD_LOAD_MAX, 3'd1, 3'd0, 16'd3);
      send_word(bsc_pkg::CMD_LOAD_ALLOC, 3'd1, 3'd0, 16'd7);
      send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom), 3'd0, 16'd3);
      run_check();
   endtask

   task automatic test_register_extremes();
      // indexes past the register list must change nothing
      csr_write(bsc_pkg::CSR_IDX_W'(2), bsc_pkg::CFG_W'($urandom));
      csr_write(bsc_pkg::CSR_IDX_W'(3), bsc_pkg::CFG_W'($urandom));
      run_check();
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(0));
      csr_write(bsc_pkg::CSR_NUM_RESOURCES, bsc_pkg::CFG_W'(0));
      run_check();
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(15));
      csr_write(bsc_pkg::CSR_NUM_RESOURCES, bsc_pkg::CFG_W'(15));
      load_coherent_region(NPROC, NRES);
      run_check();
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(8));
      csr_write(bsc_pkg::CSR_NUM_RESOURCES, bsc_pkg::CFG_W'(1));
      run_check();
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(1));
      csr_write(bsc_pkg::CSR_NUM_RESOURCES, bsc_pkg::CFG_W'(8));
      run_check();
   endtask

   // receiver sits on its ready while runs keep coming, so the block backs up
   task automatic test_back_pressure();
      csr_write(bsc_pkg::CSR_NUM_PROCESSES, bsc_pkg::CFG_W'(4));
      csr_write(bsc_pkg::CSR_NUM_RESOURCES, bsc_pkg::CFG_W'(2));
      load_coherent_region(4, 2);
      hold_pending = 1'b1;
      repeat (4) begin
         run_check();
         send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PIDX_W'($urandom),
                   bsc_pkg::RIDX_W'($urandom_range(0, 1)),
                   bsc_pkg::VALUE_W'($urandom_range(0, 10)));
      end
      run_check();
   endtask

   // sender stops until every owed completion is back, then carries on
   task automatic test_sender_pause();
      req_valid <= 1'b0;
      while (pending_completions.size() != 0) @(posedge clock);
      run_check();
      run_check();
   endtask

   task automatic test_random_traffic();
      int start, span, roll, np, nr;
      start = words_sent;
      span  = TOTAL_WORDS - start;
      while (words_sent < TOTAL_WORDS) begin
         // a stretch in the middle with both sides running flat out
         no_idle = (words_sent - start > span / 4) &&
                   (words_sent - start < (3 * span) / 4);
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            // new sizes and a fresh consistent state to go with them
            csr_write(bsc_pkg::CSR_NUM_PROCESSES, random_count());
            csr_write(bsc_pkg::CSR_NUM_RESOURCES, random_count());
            load_coherent_region(effective_count(cfg_processes, NPROC),
                                 effective_count(cfg_resources, NRES));
         end else if (roll < 70) begin
            // small tweaks inside the active region
            np = effective_count(cfg_processes, NPROC);
            nr = effective_count(cfg_resources, NRES);
            repeat ($urandom_range(1, 6))
               send_word(bsc_pkg::CMD_W'($urandom_range(0, 2)),
                         bsc_pkg::PIDX_W'($urandom_range(0, np - 1)),
                         bsc_pkg::RIDX_W'($urandom_range(0, nr - 1)),
                         bsc_pkg::VALUE_W'($urandom_range(0, 12)));
         end else if (roll < 85) begin
            // noise: full-range loads anywhere, the inactive entries too
            repeat ($urandom_range(1, 4))
               send_word(bsc_pkg::CMD_W'($urandom_range(0, 2)), bsc_pkg::PIDX_W'($urandom),
                         bsc_pkg::RIDX_W'($urandom), bsc_pkg::VALUE_W'($urandom));
         end
         run_check();
      end
      no_idle = 1'b0;
   endtask

   // receiver: random ready, with one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending && !reset) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= !reset && (no_idle || $urandom_range(0, 99) >= 11);
         end
      end
   end

   // result checker: every word taken is matched against the oldest owed one
   always @(negedge clock) begin : result_check
      result_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_completions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result word with nothing owed: process %0d unsafe %0b last %0b",
                        rsp_process_number, rsp_unsafe, rsp_last);
         end else begin
            want = pending_completions.pop_front();
            if (rsp_process_number !== want.process_number || rsp_unsafe !== want.unsafe ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want process %0d unsafe %0b last %0b, got %0d %0b %0b",
                           want.process_number, want.unsafe, want.last,
                           rsp_process_number, rsp_unsafe, rsp_last);
            end
            if (want.unsafe) unsafe_seen++;
            else picks_seen++;
         end
      end
   end

   // watchdog on cycles where no word moves anywhere
   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_directed_cases();
      test_register_extremes();
      test_back_pressure();
      test_sender_pause();
      test_random_traffic();
      // let everything owed come back, then a little longer
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d loads and %0d safety runs over %0d csr writes",
               loads_sent, runs_sent, csr_writes);
      $display("checked %0d completions and %0d unsafe verdicts, %0d mismatches",
               picks_seen, unsafe_seen, mismatches);
      if (mismatches == 0 && pending_completions.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
